// ----- hw/rtl/nlda_pkg.sv -----
package nlda_pkg;

  localparam int YEAR_IN_W  = 14;
  localparam int YEAR_OUT_W = 15;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int DOY_W      = 9;   // day of year, up to 365 + 31
  localparam int SUM_W      = 10;  // sum of two day-of-year values

  localparam logic [DOY_W-1:0] DAYS_PER_YEAR = 9'd365;
  localparam logic [MONTH_W-1:0] MONTHS      = 4'd12;

  localparam logic       FUNC_ADD = 1'b0;
  localparam logic       FUNC_SUB = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [YEAR_IN_W-1:0]  year_first;
    logic [MONTH_W-1:0]    month_first;
    logic [DAY_W-1:0]      day_first;
    logic [YEAR_IN_W-1:0]  year_second;
    logic [MONTH_W-1:0]    month_second;
    logic [DAY_W-1:0]      day_second;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_OUT_W-1:0] year_out;
    logic [MONTH_W-1:0]    month_out;
    logic [DAY_W-1:0]      day_out;
    logic                  underflow;
  } out_item_t;

  // Days in the year before the first day of month m (no leap years).
  // Months 0 and 1 start at zero; any code past December counts the full year.
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] c;
    case (m) inside
      4'd0, 4'd1: c = 9'd0;
      4'd2:       c = 9'd31;
      4'd3:       c = 9'd59;
      4'd4:       c = 9'd90;
      4'd5:       c = 9'd120;
      4'd6:       c = 9'd151;
      4'd7:       c = 9'd181;
      4'd8:       c = 9'd212;
      4'd9:       c = 9'd243;
      4'd10:      c = 9'd273;
      4'd11:      c = 9'd304;
      4'd12:      c = 9'd334;
      default:    c = DAYS_PER_YEAR;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/nlda_doy.sv -----
module nlda_doy (
  input  logic [nlda_pkg::MONTH_W-1:0] month,
  input  logic [nlda_pkg::DAY_W-1:0]   day,
  output logic [nlda_pkg::DOY_W-1:0]   doy
);

  // month offset plus unchecked day
  assign doy = nlda_pkg::cum_days(month)
             + {{(nlda_pkg::DOY_W - nlda_pkg::DAY_W){1'b0}}, day};

endmodule

// ----- hw/rtl/nlda_md.sv -----
module nlda_md (
  input  logic [nlda_pkg::DOY_W-1:0]   doy,
  output logic [nlda_pkg::MONTH_W-1:0] month,
  output logic [nlda_pkg::DAY_W-1:0]   day
);

  logic [nlda_pkg::MONTH_W-1:0] m_sel;
  logic [nlda_pkg::DOY_W-1:0]   rem;

  // first month whose last day is at or beyond the count
  always_comb begin
    m_sel = nlda_pkg::MONTHS;
    for (int i = 12; i >= 1; i--) begin
      if (doy <= nlda_pkg::cum_days(nlda_pkg::MONTH_W'(i + 1))) begin
        m_sel = nlda_pkg::MONTH_W'(i);
      end
    end
  end

  assign rem = doy - nlda_pkg::cum_days(m_sel);

  // counts past the year end saturate to December 31
  always_comb begin
    if (doy > nlda_pkg::DAYS_PER_YEAR) begin
      month = nlda_pkg::MONTHS;
      day   = 5'd31;
    end else begin
      month = m_sel;
      day   = rem[nlda_pkg::DAY_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/nlda_core.sv -----
module nlda_core (
  input  nlda_pkg::in_item_t  item_i,
  output nlda_pkg::out_item_t item_o
);

  localparam int YW = nlda_pkg::YEAR_OUT_W;
  localparam int DW = nlda_pkg::DOY_W;
  localparam int SW = nlda_pkg::SUM_W;

  logic [DW-1:0] n1, n2;
  logic [SW-1:0] sum, sum_mod;
  logic [DW-1:0] add_cnt, sub_cnt, conv_cnt;
  logic [YW-1:0] y1, y2, add_year, sub_year;
  logic          carry, borrow, under;
  logic [nlda_pkg::MONTH_W-1:0] mon;
  logic [nlda_pkg::DAY_W-1:0]   dd;

  nlda_doy u_doy1 (.month(item_i.month_first),  .day(item_i.day_first),  .doy(n1));
  nlda_doy u_doy2 (.month(item_i.month_second), .day(item_i.day_second), .doy(n2));

  assign y1 = {1'b0, item_i.year_first};
  assign y2 = {1'b0, item_i.year_second};

  // add: carry past year end, reduce modulo 365 (sum stays below 3 years)
  assign sum   = {1'b0, n1} + {1'b0, n2};
  assign carry = (sum > {1'b0, nlda_pkg::DAYS_PER_YEAR});
  always_comb begin
    if (sum >= 10'd730) begin
      sum_mod = sum - 10'd730;
    end else if (carry || sum == {1'b0, nlda_pkg::DAYS_PER_YEAR}) begin
      sum_mod = sum - {1'b0, nlda_pkg::DAYS_PER_YEAR};
    end else begin
      sum_mod = sum;
    end
  end
  assign add_cnt  = (sum_mod == '0) ? nlda_pkg::DAYS_PER_YEAR : sum_mod[DW-1:0];
  assign add_year = y1 + y2 + {{(YW-1){1'b0}}, carry};

  // subtract: underflow check, borrow a year when first day count is smaller
  assign borrow   = (n1 < n2);
  assign under    = (y1 < y2) || ((y1 == y2) && borrow);
  assign sub_cnt  = borrow ? (n1 + nlda_pkg::DAYS_PER_YEAR - n2) : (n1 - n2);
  assign sub_year = y1 - y2 - {{(YW-1){1'b0}}, borrow};

  assign conv_cnt = (item_i.func == nlda_pkg::FUNC_SUB) ? sub_cnt : add_cnt;

  nlda_md u_md (.doy(conv_cnt), .month(mon), .day(dd));

  // result select
  always_comb begin
    if (item_i.func == nlda_pkg::FUNC_SUB && under) begin
      item_o.year_out  = '0;
      item_o.month_out = 4'd1;
      item_o.day_out   = '0;
      item_o.underflow = 1'b1;
    end else begin
      item_o.year_out  = (item_i.func == nlda_pkg::FUNC_SUB) ? sub_year : add_year;
      item_o.month_out = mon;
      item_o.day_out   = dd;
      item_o.underflow = 1'b0;
    end
  end

endmodule

// ----- hw/rtl/noleap_date_add_subtract_top.sv -----
// Channel | Ports                          | Item
// input   | in_valid, in_ready, in_item    | nlda_pkg::in_item_t (two dates, func)
// result  | out_valid, out_ready, out_item | nlda_pkg::out_item_t (date, underflow)
//
// Two register stages: input register, then the date arithmetic, then the
// result register. One item per cycle sustained while the result side is ready.
// The rate is set by the single combinational pass through nlda_core.
// rst_n (synchronous, active low) empties both stages.
// A stalled result holds in place while the input register may still fill.
module noleap_date_add_subtract_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nlda_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output nlda_pkg::out_item_t out_item
);

  logic                s1_valid_r, s1_valid_nxt;
  nlda_pkg::in_item_t  s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  nlda_pkg::out_item_t out_item_r;
  nlda_pkg::out_item_t calc_item;
  logic                out_take;

  // stage advance
  assign out_take = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_take;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_take) begin
      out_valid_nxt = s1_valid_r;
    end
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
    if (out_take && s1_valid_r) begin
      out_item_r <= calc_item;
    end
  end

  nlda_core u_core (.item_i(s1_item_r), .item_o(calc_item));

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- hw/rtl/nlda_checker.sv -----
module nlda_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input nlda_pkg::out_item_t out_item
);

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("result changed while stalled");

  // underflow result is the fixed zero date
  a_under_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.underflow |->
      out_item.year_out == '0 && out_item.month_out == 4'd1 && out_item.day_out == '0)
    else $error("underflow result not zeroed");

  // month always lands in 1..12
  a_month_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.month_out >= 4'd1 && out_item.month_out <= 4'd12)
    else $error("month out of range");

  // reset empties the result stage
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind noleap_date_add_subtract_top nlda_checker u_nlda_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item(out_item)
);

// ----- tb/date_result_checker.sv -----
// Watches both channels of the date block, predicts each result from the
// accepted input item and compares it with what comes out.
module date_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  nlda_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  nlda_pkg::out_item_t out_item,
  output int                  mismatches,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned DPY = 32'(nlda_pkg::DAYS_PER_YEAR);

  nlda_pkg::out_item_t due_results[$];
  int                  err_cnt = 0;

  // Month/day to a running day count; month codes past December count the full year.
  function automatic int unsigned day_index(logic [nlda_pkg::MONTH_W-1:0] m,
                                            logic [nlda_pkg::DAY_W-1:0] d);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 12; i++) begin
      if (i + 1 < m) n += MONTH_LEN[4'(i)];
    end
    return n + 32'(d);
  endfunction

  // Expected result for one input item.
  function automatic nlda_pkg::out_item_t predict_date_result(nlda_pkg::in_item_t it);
    nlda_pkg::out_item_t r;
    int unsigned n1;
    int unsigned n2;
    int unsigned cnt;
    int unsigned yr;
    bit          placed;
    r           = '0;
    r.month_out = 4'd1;
    n1 = day_index(it.month_first, it.day_first);
    n2 = day_index(it.month_second, it.day_second);
    if (it.func == nlda_pkg::FUNC_ADD) begin
      cnt = n1 + n2;
      yr  = 32'(it.year_first) + 32'(it.year_second) + ((cnt > DPY) ? 32'd1 : 32'd0);
      cnt = cnt % DPY;
      if (cnt == 0) cnt = DPY;
    end else begin
      // first date earlier: fixed underflow result
      if (it.year_first < it.year_second ||
          (it.year_first == it.year_second && n1 < n2)) begin
        r.underflow = 1'b1;
        return r;
      end
      yr = 32'(it.year_first);
      if (n1 < n2) begin
        yr -= 1;
        n1 += DPY;
      end
      yr -= 32'(it.year_second);
      cnt = n1 - n2;
    end
    r.year_out = nlda_pkg::YEAR_OUT_W'(yr);
    // back to month/day, saturating at the last day of December
    r.month_out = nlda_pkg::MONTHS;
    r.day_out   = 5'd31;
    placed = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (!placed) begin
        if (MONTH_LEN[4'(i)] < cnt) begin
          cnt -= MONTH_LEN[4'(i)];
        end else begin
          r.month_out = nlda_pkg::MONTH_W'(i + 1);
          r.day_out   = nlda_pkg::DAY_W'(cnt);
          placed      = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Track accepted items and check results in order.
  always @(posedge clk) begin : watch
    nlda_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) due_results.push_back(predict_date_result(in_item));
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result with nothing due: year %0d month %0d day %0d uf %0b",
                     $realtime, out_item.year_out, out_item.month_out, out_item.day_out,
                     out_item.underflow);
        end else begin
          want = due_results.pop_front();
          if (want.year_out !== out_item.year_out || want.month_out !== out_item.month_out ||
              want.day_out !== out_item.day_out || want.underflow !== out_item.underflow) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch exp y %0d m %0d d %0d uf %0b, got y %0d m %0d d %0d uf %0b",
                       $realtime, want.year_out, want.month_out, want.day_out, want.underflow,
                       out_item.year_out, out_item.month_out, out_item.day_out,
                       out_item.underflow);
          end
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= due_results.size();
  end

endmodule

// ----- tb/noleap_date_add_subtract_top_tb.sv -----
// Drives date items into the block in bursts, stalls the result side and
// reports the verdict from the checker's counts.
module noleap_date_add_subtract_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  nlda_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  nlda_pkg::out_item_t out_item;

  int mismatches;
  int outstanding;
  int burst_left = 0;
  int rx_mode    = 0;
  int rx_left    = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  noleap_date_add_subtract_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  date_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Result side: modes of always ready, coin flip, and long stalls
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic nlda_pkg::in_item_t date_pair(logic f, int y1, int m1, int d1,
                                                   int y2, int m2, int d2);
    nlda_pkg::in_item_t it;
    it.func         = f;
    it.year_first   = y1[13:0];
    it.month_first  = m1[3:0];
    it.day_first    = d1[4:0];
    it.year_second  = y2[13:0];
    it.month_second = m2[3:0];
    it.day_second   = d2[4:0];
    return it;
  endfunction

  // One item; opens a random gap when the current burst is used up.
  task automatic send_date_item(input nlda_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 7);
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every due result has come back.
  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    nlda_pkg::in_item_t it;
    int pick;
    int ysel;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, carry, borrow, underflow, odd months and days
    send_date_item(date_pair(nlda_pkg::FUNC_ADD, 0, 1, 1, 0, 1, 1));
    send_date_item(date_pair(nlda_pkg::FUNC_ADD, 16383, 12, 31, 16383, 12, 31));
    send_date_item(date_pair(nlda_pkg::FUNC_ADD, 2000, 12, 31, 5, 1, 1));
    send_date_item(date_pair(nlda_pkg::FUNC_ADD, 10, 6, 15, 3, 0, 0));
    send_date_item(date_pair(nlda_pkg::FUNC_ADD, 1, 13, 31, 1, 15, 31));
    send_date_item(date_pair(nlda_pkg::FUNC_ADD, 0, 2, 31, 0, 4, 31));
    send_date_item(date_pair(nlda_pkg::FUNC_ADD, 16383, 15, 31, 16383, 15, 31));
    send_date_item(date_pair(nlda_pkg::FUNC_ADD, 0, 0, 0, 0, 0, 0));
    send_date_item(date_pair(nlda_pkg::FUNC_ADD, 7, 3, 1, 9, 9, 30));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 2024, 3, 14, 2024, 3, 14));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 5, 1, 1, 6, 1, 1));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 7, 3, 1, 7, 3, 2));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 10, 1, 5, 3, 12, 25));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 16383, 12, 31, 0, 1, 1));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 4, 15, 31, 4, 0, 0));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 9, 0, 0, 9, 0, 0));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 100, 13, 0, 99, 12, 31));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 16383, 15, 31, 0, 0, 0));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 0, 0, 0, 16383, 15, 31));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 1, 1, 1, 0, 12, 31));
    send_date_item(date_pair(nlda_pkg::FUNC_SUB, 3, 2, 31, 3, 2, 28));
    drain_results();

    // random: mostly valid calendar dates, some raw field values
    for (int k = 0; k < 1900; k++) begin
      it.func = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        it.month_first  = 4'($urandom_range(1, 12));
        it.day_first    = 5'($urandom_range(1, MONTH_LEN[it.month_first - 4'd1]));
        it.month_second = 4'($urandom_range(1, 12));
        it.day_second   = 5'($urandom_range(1, MONTH_LEN[it.month_second - 4'd1]));
      end else begin
        it.month_first  = 4'($urandom_range(0, 15));
        it.day_first    = 5'($urandom_range(0, 31));
        it.month_second = 4'($urandom_range(0, 15));
        it.day_second   = 5'($urandom_range(0, 31));
      end
      ysel = $urandom_range(0, 3);
      it.year_first = 14'($urandom_range(0, 16383));
      case (ysel)
        0:       it.year_second = 14'($urandom_range(0, 16383));
        1:       it.year_second = it.year_first;
        2:       it.year_second = it.year_first - 14'($urandom_range(0, 2));
        default: begin
          it.year_first  = 14'($urandom_range(0, 3));
          it.year_second = 14'($urandom_range(0, 3));
        end
      endcase
      // occasionally the same date twice
      if ($urandom_range(0, 15) == 0) begin
        it.year_second  = it.year_first;
        it.month_second = it.month_first;
        it.day_second   = it.day_first;
      end
      send_date_item(it);
      if (k == 950) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("noleap_date_add_subtract_top test passed");
    end else begin
      $display("noleap_date_add_subtract_top test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("noleap_date_add_subtract_top test failed");
    $finish;
  end

endmodule
